>>> rtl/mbrw_pkg.sv
// Shared constants, types and a helper function for the macroblock-to-raster writer.
`timescale 1ns / 1ps

package mbrw_pkg;

	localparam int MAX_MB_COLS = 128;
	localparam int MAX_MB_ROWS = 128;

	localparam int COL_W    = $clog2(MAX_MB_COLS);
	localparam int ROW_W    = $clog2(MAX_MB_ROWS);
	localparam int DIM_W    = 8;
	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 9;
	localparam int ADDR_W   = 22;
	localparam int PIXEL_W  = 8;
	localparam int PLANE_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [IDX_W-1:0] LUMA_SAMPLES = 9'd256;
	localparam logic [IDX_W-1:0] LAST_IDX     = 9'd383;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MB_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_MB_ROWS = 2'd1;

	typedef enum logic [PLANE_W-1:0] {
		PLANE_Y = 2'd0,
		PLANE_U = 2'd1,
		PLANE_V = 2'd2
	} plane_t;

	typedef struct packed {
		logic                 we;
		logic [CFG_IDX_W-1:0] index;
		logic [DIM_W-1:0]     data;
	} cfg_wr_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [DIM_W-1:0] cols;
		logic             done;
	} pos_t;

	// Geometry in use: zero counts as one, anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> rtl/mbrw_position.sv
// Geometry registers and the macroblock position and sample counters.
`timescale 1ns / 1ps

module mbrw_position import mbrw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    step,
	output pos_t    pos
);

	logic [DIM_W-1:0] cols_cfg_q;
	logic [DIM_W-1:0] rows_cfg_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [IDX_W-1:0] idx_q;

	logic [DIM_W-1:0] cols_eff;
	logic [DIM_W-1:0] rows_eff;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic [ROW_W:0]   row_adv;
	logic             wrap_col;
	logic             last_mb;
	logic             last_idx;

	assign cols_eff = eff_dim(cols_cfg_q, DIM_W'(MAX_MB_COLS));
	assign rows_eff = eff_dim(rows_cfg_q, DIM_W'(MAX_MB_ROWS));

	// The edge test is "at or beyond", so a position left outside a shrunken frame still wraps.
	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign wrap_col = col_inc >= cols_eff;
	assign row_adv  = wrap_col ? row_inc : {1'b0, row_q};
	assign last_mb  = row_adv >= rows_eff;
	assign last_idx = idx_q == LAST_IDX;

	always_comb begin
		pos.idx  = idx_q;
		pos.col  = col_q;
		pos.row  = row_q;
		pos.cols = cols_eff;
		pos.done = last_idx && last_mb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= DIM_W'(1);
			rows_cfg_q <= DIM_W'(1);
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_FRAME_MB_COLS: cols_cfg_q <= cfg.data;
				REG_FRAME_MB_ROWS: rows_cfg_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			idx_q <= '0;
		end else if (step) begin
			if (last_idx) begin
				idx_q <= '0;
				if (last_mb) begin
					col_q <= '0;
					row_q <= '0;
				end else if (wrap_col) begin
					col_q <= '0;
					row_q <= row_inc[ROW_W-1:0];
				end else begin
					col_q <= col_inc[COL_W-1:0];
				end
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

>>> rtl/mbrw_addr_gen.sv
// Plane select, raster address and pixel clamp for one sample.
`timescale 1ns / 1ps

module mbrw_addr_gen import mbrw_pkg::*; (
	input  pos_t                       pos,
	input  logic signed [SAMPLE_W-1:0] sample,
	output plane_t                     plane,
	output logic [ADDR_W-1:0]          address,
	output logic [PIXEL_W-1:0]         pixel
);

	localparam int YL_W   = ROW_W + 4;
	localparam int XL_W   = COL_W + 4;
	localparam int YC_W   = ROW_W + 3;
	localparam int XC_W   = COL_W + 3;
	localparam int PROD_W = YL_W + DIM_W;
	localparam int SUM_W  = PROD_W + 4;

	logic              luma;
	logic [YL_W-1:0]   y_luma;
	logic [XL_W-1:0]   x_luma;
	logic [YC_W-1:0]   y_chr;
	logic [XC_W-1:0]   x_chr;
	logic [YL_W-1:0]   y_sel;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  addr_full;

	assign luma = pos.idx < LUMA_SAMPLES;

	// Luma blocks sit two by two; bit 7 picks the lower pair, bit 6 the right one.
	assign y_luma = {pos.row, pos.idx[7], pos.idx[5:3]};
	assign x_luma = {pos.col, pos.idx[6], pos.idx[2:0]};
	assign y_chr  = {pos.row, pos.idx[5:3]};
	assign x_chr  = {pos.col, pos.idx[2:0]};

	// A luma row is cols*16 bytes and a chroma row cols*8, so one multiply by cols serves both.
	assign y_sel = luma ? y_luma : {1'b0, y_chr};
	assign prod  = y_sel * pos.cols;

	always_comb begin
		if (luma) begin
			addr_full = {prod, 4'b0} + SUM_W'(x_luma);
		end else begin
			addr_full = {1'b0, prod, 3'b0} + SUM_W'(x_chr);
		end
	end

	assign address = addr_full[ADDR_W-1:0];

	always_comb begin
		if (luma) begin
			plane = PLANE_Y;
		end else if (pos.idx[6]) begin
			plane = PLANE_V;
		end else begin
			plane = PLANE_U;
		end
	end

	always_comb begin
		if (sample[SAMPLE_W-1]) begin
			pixel = '0;
		end else if (|sample[SAMPLE_W-2:PIXEL_W]) begin
			pixel = '1;
		end else begin
			pixel = sample[PIXEL_W-1:0];
		end
	end

endmodule

>>> rtl/macroblock_to_raster_writer.sv
// Top level of the 4:2:0 macroblock-to-raster writer.
`timescale 1ns / 1ps

// Takes one signed sample per beat, 384 per macroblock (four 8x8 luma blocks in raster
// order, then U, then V), and gives one frame-buffer write per sample: plane, byte address
// within that plane and the pixel clamped to 0..255; frame_done marks the frame's last write.
// The block sustains one sample per clock. Each beat passes two registers inside: an input
// register that captures the sample with its macroblock position, then the address multiply
// and clamp into the result register. A stalled output holds the pipeline. Geometry written
// on the configuration port applies to the next sample taken and should be written while idle.
module macroblock_to_raster_writer import mbrw_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [DIM_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [PLANE_W-1:0]         plane,
	output logic [ADDR_W-1:0]          address,
	output logic [PIXEL_W-1:0]         pixel,
	output logic                       frame_done
);

	cfg_wr_t cfg;
	pos_t    pos;
	pos_t    pos_s1;
	plane_t  plane_c;
	logic [ADDR_W-1:0]  address_c;
	logic [PIXEL_W-1:0] pixel_c;

	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       valid_s1;
	plane_t                     plane_s2;
	logic [ADDR_W-1:0]          address_s2;
	logic [PIXEL_W-1:0]         pixel_s2;
	logic                       done_s2;
	logic                       valid_s2;

	logic advance;
	logic in_fire;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// The result register moves on when it is empty or being taken; the input register may
	// still fill while it is empty.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = advance || !valid_s1;
	assign in_fire  = in_valid && in_ready;

	mbrw_position u_position (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (in_fire),
		.pos    (pos)
	);

	mbrw_addr_gen u_addr_gen (
		.pos     (pos_s1),
		.sample  (sample_s1),
		.plane   (plane_c),
		.address (address_c),
		.pixel   (pixel_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= sample;
			pos_s1    <= pos;
		end
		if (advance) begin
			plane_s2   <= plane_c;
			address_s2 <= address_c;
			pixel_s2   <= pixel_c;
			done_s2    <= pos_s1.done;
		end
	end

	assign out_valid  = valid_s2;
	assign plane      = plane_s2;
	assign address    = address_s2;
	assign pixel      = pixel_s2;
	assign frame_done = done_s2;

	// The frame always ends on the last V sample of a macroblock.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> plane == PLANE_V)
	else $error("frame end flagged on a sample that is not the last V sample");

	// Input back-pressure only ever comes from a full pipeline facing a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid && !out_ready)
	else $error("input stalled while the pipeline had room");

	// The sample counter never leaves the macroblock.
	assert property (@(posedge clk) disable iff (!arst_n)
		pos.idx <= LAST_IDX)
	else $error("sample index ran past the end of the macroblock");

	// An item held in the input register during a stall keeps its position.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> $stable(pos_s1))
	else $error("stalled input register changed");

endmodule
